// ===== design/antialiased_line_raster_assert.svh =====
// Assertion macros shared by the line rasterizer RTL.
`ifndef ANTIALIASED_LINE_RASTER_ASSERT_SVH
`define ANTIALIASED_LINE_RASTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AALR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AALR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/aalr_pkg.sv =====
// Types and constants of the antialiased line rasterizer.
`default_nettype none

package aalr_pkg;

	localparam int CoordW   = 17;
	localparam int ErrW     = 18;
	localparam int DeltaW   = 17;
	localparam int CanvasW  = 13;
	localparam int PixW     = 12;
	localparam int WeightW  = 9;
	localparam int RegIdxW  = 1;
	localparam int DivSteps = 9;
	localparam int DivCntW  = 4;

	localparam logic [WeightW-1:0] FullWeight = 9'd256;
	localparam logic [CanvasW-1:0] CanvasReset = 13'd4096;

	localparam logic OpStart = 1'b0;
	localparam logic OpStep  = 1'b1;

	localparam logic [RegIdxW-1:0] RegCanvasWidth  = 1'd0;
	localparam logic [RegIdxW-1:0] RegCanvasHeight = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADVANCE,
		S_DIV,
		S_WEIGH,
		S_CHECK,
		S_EMIT0,
		S_EMIT1
	} state_t;

endpackage

`default_nettype wire

// ===== design/antialiased_line_raster.sv =====
// Antialiased line rasterizer: top level with sequencer and shared divider.
//
// Usage. A start item (opcode 0) loads both endpoints and the color and
// produces the first endpoint at full coverage. Each step item (opcode 1)
// advances the major axis by one and produces up to two pixels, the main
// pixel and its side neighbor, whose coverages add up to 256. Pixels off the
// canvas or with zero coverage are dropped, and last_of_item marks the final
// pixel of an item. A step item with no line running gives no pixels.
// The user must write the canvas size through the cfg channel only while the
// block is idle; the block itself does not enforce this.
// Sequence. A start item goes through CHECK and EMIT0; a step item goes through
// ADVANCE, DIV, WEIGH, CHECK, EMIT0 and, for a second pixel, EMIT1. DIV is the
// weight division, a restoring compare-and-subtract unit that produces one of
// the 9 quotient bits per cycle. in_ready is high only while the sequencer is
// idle, so one item is in work at a time and a new item is not taken before the
// last one is through.
// The result register holds a pixel while out_ready is low and the sequencer
// waits for it; the next item is accepted as soon as the last pixel of the
// current one has been loaded into that register.
// Reset clears the line state and returns both canvas registers to 4096.
`default_nettype none

module antialiased_line_raster #(
	parameter int COORD_BITS = 16,
	parameter int MAX_CANVAS = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   opcode,
	input  wire logic signed [15:0]     start_x,
	input  wire logic signed [15:0]     start_y,
	input  wire logic signed [15:0]     end_x,
	input  wire logic signed [15:0]     end_y,
	input  wire logic [31:0]            line_color,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [11:0]                 pixel_x,
	output logic [11:0]                 pixel_y,
	output logic [8:0]                  coverage,
	output logic [7:0]                  chan0,
	output logic [7:0]                  chan1,
	output logic [7:0]                  chan2,
	output logic [7:0]                  chan3,
	output logic                        last_of_item,
	output logic                        line_done,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [0:0]             cfg_index,
	input  wire logic [12:0]            cfg_data
);

	localparam int CoordW = aalr_pkg::CoordW;
	localparam int ErrW   = aalr_pkg::ErrW;
	localparam int DeltaW = aalr_pkg::DeltaW;
	localparam int CanvW  = aalr_pkg::CanvasW;
	localparam int WW     = aalr_pkg::WeightW;
	localparam int CntW   = aalr_pkg::DivCntW;
	localparam int InBits = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int ExtW   = CoordW - InBits;
	localparam int CalcW  = 20;
	localparam int PosW   = 18;
	localparam logic [DeltaW-1:0] MaxCanvasC = DeltaW'(MAX_CANVAS);

	aalr_pkg::state_t state_q, state_d;

	logic [CanvW-1:0]         canvas_w_q, canvas_h_q;
	logic signed [CoordW-1:0] cur_x_q, cur_y_q;
	logic signed [ErrW-1:0]   err_q;
	logic [DeltaW-1:0]        major_q, minor_q, steps_q;
	logic                     x_neg_q, y_neg_q, x_major_q;
	logic [31:0]              color_q;

	logic signed [PosW-1:0]   px0_q, py0_q, px1_q, py1_q;
	logic [WW-1:0]            w0_q, w1_q;
	logic                     pass0_q, pass1_q;
	logic [PosW-1:0]          rem_q;
	logic [WW-1:0]            quot_q;
	logic [CntW-1:0]          cnt_q;

	logic                     out_valid_q;
	logic [11:0]              pixel_x_q, pixel_y_q;
	logic [WW-1:0]            coverage_q;
	logic [7:0]               chan_q [4];
	logic                     last_q, done_q;

	logic out_free, out_load, out_sel, out_last;
	logic in_accept;

	// Start decode.
	logic signed [CoordW-1:0] x1, y1, x2, y2;
	logic signed [PosW-1:0]   dx, dy;
	logic [DeltaW-1:0]        ax, ay;

	assign x1 = {{ExtW{start_x[InBits-1]}}, start_x[InBits-1:0]};
	assign y1 = {{ExtW{start_y[InBits-1]}}, start_y[InBits-1:0]};
	assign x2 = {{ExtW{end_x[InBits-1]}}, end_x[InBits-1:0]};
	assign y2 = {{ExtW{end_y[InBits-1]}}, end_y[InBits-1:0]};
	assign dx = PosW'(x2) - PosW'(x1);
	assign dy = PosW'(y2) - PosW'(y1);
	assign ax = dx[PosW-1] ? DeltaW'(-dx) : DeltaW'(dx);
	assign ay = dy[PosW-1] ? DeltaW'(-dy) : DeltaW'(dy);

	// Error update of one major-axis step.
	logic signed [CalcW-1:0] m_cur, mn_cur, minc, ninc, m_new, mn_new, s_new;
	logic signed [CalcW-1:0] d0, d_new, major_c, ad_c;

	always_comb begin
		m_cur   = x_major_q ? CalcW'(cur_x_q) : CalcW'(cur_y_q);
		mn_cur  = x_major_q ? CalcW'(cur_y_q) : CalcW'(cur_x_q);
		minc    = (x_major_q ? x_neg_q : y_neg_q) ? -CalcW'(1) : CalcW'(1);
		ninc    = (x_major_q ? y_neg_q : x_neg_q) ? -CalcW'(1) : CalcW'(1);
		major_c = CalcW'(major_q);
		m_new   = m_cur + minc;
		d0      = CalcW'(err_q) + CalcW'(minor_q);
		mn_new  = mn_cur;
		d_new   = d0;
		if (d0 <= 0) begin
			s_new = mn_cur - ninc;
		end else if (d0 - major_c < 0) begin
			if (d0 + d0 - major_c <= 0) begin
				s_new = mn_cur + ninc;
			end else begin
				s_new  = mn_cur;
				mn_new = mn_cur + ninc;
				d_new  = d0 - major_c;
			end
		end else begin
			mn_new = mn_cur + ninc;
			s_new  = mn_cur + ninc + ninc;
			d_new  = d0 - major_c;
		end
		ad_c = (d_new < 0) ? -d_new : d_new;
	end

	// Shared compare-and-subtract unit of the weight division.
	logic [PosW-1:0] div_diff;
	logic            div_ge;

	assign div_ge   = rem_q >= PosW'(major_q);
	assign div_diff = rem_q - PosW'(major_q);

	// Canvas limits and visibility test.
	logic [DeltaW-1:0] lim_w, lim_h;

	assign lim_w = (DeltaW'(canvas_w_q) > MaxCanvasC) ? MaxCanvasC : DeltaW'(canvas_w_q);
	assign lim_h = (DeltaW'(canvas_h_q) > MaxCanvasC) ? MaxCanvasC : DeltaW'(canvas_h_q);

	function automatic logic visible(input logic signed [PosW-1:0] px,
		input logic signed [PosW-1:0] py, input logic [WW-1:0] w,
		input logic [DeltaW-1:0] lw, input logic [DeltaW-1:0] lh);
		visible = (w != '0) && !px[PosW-1] && !py[PosW-1]
			&& (px[DeltaW-1:0] < lw) && (py[DeltaW-1:0] < lh);
	endfunction

	assign in_ready  = (state_q == aalr_pkg::S_IDLE);
	assign in_accept = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aalr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		out_sel  = 1'b0;
		out_last = 1'b0;
		unique case (state_q)
			aalr_pkg::S_IDLE: begin
				if (in_valid) begin
					if (opcode == aalr_pkg::OpStart) begin
						state_d = aalr_pkg::S_CHECK;
					end else if (steps_q != '0 && major_q != '0) begin
						state_d = aalr_pkg::S_ADVANCE;
					end
				end
			end
			aalr_pkg::S_ADVANCE: state_d = aalr_pkg::S_DIV;
			aalr_pkg::S_DIV: begin
				if (cnt_q == CntW'(1)) begin
					state_d = aalr_pkg::S_WEIGH;
				end
			end
			aalr_pkg::S_WEIGH: state_d = aalr_pkg::S_CHECK;
			aalr_pkg::S_CHECK: state_d = aalr_pkg::S_EMIT0;
			aalr_pkg::S_EMIT0: begin
				if (!pass0_q) begin
					state_d = pass1_q ? aalr_pkg::S_EMIT1 : aalr_pkg::S_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					out_last = !pass1_q;
					state_d  = pass1_q ? aalr_pkg::S_EMIT1 : aalr_pkg::S_IDLE;
				end
			end
			aalr_pkg::S_EMIT1: begin
				if (!pass1_q) begin
					state_d = aalr_pkg::S_IDLE;
				end else if (out_free) begin
					out_load = 1'b1;
					out_sel  = 1'b1;
					out_last = 1'b1;
					state_d  = aalr_pkg::S_IDLE;
				end
			end
			default: state_d = aalr_pkg::S_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= aalr_pkg::CanvasReset;
			canvas_h_q <= aalr_pkg::CanvasReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				aalr_pkg::RegCanvasWidth:  canvas_w_q <= cfg_data;
				aalr_pkg::RegCanvasHeight: canvas_h_q <= cfg_data;
			endcase
		end
	end

	// Line state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			err_q     <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			steps_q   <= '0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			x_major_q <= 1'b0;
			color_q   <= '0;
			cnt_q     <= '0;
		end else begin
			if (in_accept && opcode == aalr_pkg::OpStart) begin
				cur_x_q   <= x1;
				cur_y_q   <= y1;
				err_q     <= '0;
				x_neg_q   <= (dx <= 0);
				y_neg_q   <= (dy <= 0);
				x_major_q <= (ax >= ay);
				major_q   <= (ax >= ay) ? ax : ay;
				minor_q   <= (ax >= ay) ? ay : ax;
				steps_q   <= (ax >= ay) ? ax : ay;
				color_q   <= line_color;
			end
			if (state_q == aalr_pkg::S_ADVANCE) begin
				cur_x_q <= x_major_q ? CoordW'(m_new) : CoordW'(mn_new);
				cur_y_q <= x_major_q ? CoordW'(mn_new) : CoordW'(m_new);
				err_q   <= ErrW'(d_new);
				steps_q <= steps_q - DeltaW'(1);
				cnt_q   <= CntW'(aalr_pkg::DivSteps);
			end
			if (state_q == aalr_pkg::S_DIV) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	// Pixel candidates and the division datapath.
	always_ff @(posedge clk) begin
		if (in_accept && opcode == aalr_pkg::OpStart) begin
			px0_q <= PosW'(x1);
			py0_q <= PosW'(y1);
			px1_q <= PosW'(x1);
			py1_q <= PosW'(y1);
			w0_q  <= aalr_pkg::FullWeight;
			w1_q  <= '0;
		end
		if (state_q == aalr_pkg::S_ADVANCE) begin
			px0_q  <= x_major_q ? PosW'(m_new) : PosW'(mn_new);
			py0_q  <= x_major_q ? PosW'(mn_new) : PosW'(m_new);
			px1_q  <= x_major_q ? PosW'(m_new) : PosW'(s_new);
			py1_q  <= x_major_q ? PosW'(s_new) : PosW'(m_new);
			rem_q  <= PosW'(ad_c);
			quot_q <= '0;
		end
		if (state_q == aalr_pkg::S_DIV) begin
			rem_q  <= {(div_ge ? div_diff[PosW-2:0] : rem_q[PosW-2:0]), 1'b0};
			quot_q <= {quot_q[WW-2:0], div_ge};
		end
		if (state_q == aalr_pkg::S_WEIGH) begin
			w1_q <= quot_q;
			w0_q <= aalr_pkg::FullWeight - quot_q;
		end
		if (state_q == aalr_pkg::S_CHECK) begin
			pass0_q <= visible(px0_q, py0_q, w0_q, lim_w, lim_h);
			pass1_q <= visible(px1_q, py1_q, w1_q, lim_w, lim_h);
		end
	end

	// Result register.
	logic [PosW-1:0] sel_x, sel_y;
	logic [WW-1:0]   sel_w;
	logic [16:0]     prod [4];

	assign sel_x = out_sel ? px1_q : px0_q;
	assign sel_y = out_sel ? py1_q : py0_q;
	assign sel_w = out_sel ? w1_q : w0_q;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			prod[k] = {9'b0, color_q[8*k +: 8]} * {8'b0, sel_w};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_x_q  <= sel_x[11:0];
			pixel_y_q  <= sel_y[11:0];
			coverage_q <= sel_w;
			for (int k = 0; k < 4; k++) begin
				chan_q[k] <= prod[k][15:8];
			end
			last_q <= out_last;
			done_q <= (steps_q == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign coverage     = coverage_q;
	assign chan0        = chan_q[0];
	assign chan1        = chan_q[1];
	assign chan2        = chan_q[2];
	assign chan3        = chan_q[3];
	assign last_of_item = last_q;
	assign line_done    = done_q;

	logic [PosW-1:0] major_x2;
	assign major_x2 = {major_q, 1'b0};

	`include "antialiased_line_raster_assert.svh"

	`AALR_ASSERT_NOW(a_div_rem_bound, state_q == aalr_pkg::S_DIV, rem_q < major_x2, "Division remainder out of range.")
	`AALR_ASSERT_NEXT(a_step_count, state_q == aalr_pkg::S_ADVANCE, steps_q == $past(steps_q) - DeltaW'(1), "Step counter did not decrement.")
	`AALR_ASSERT_NOW(a_weight_sum, state_q == aalr_pkg::S_CHECK, (10'(w0_q) + 10'(w1_q)) == 10'd256, "Pixel weights do not add up to 256.")
	`AALR_ASSERT_NOW(a_cov_nonzero, out_valid_q, coverage_q != '0, "Pixel item with zero coverage.")

endmodule

`default_nettype wire

// ===== tb/antialiased_line_raster_test.sv =====
// Self-checking testbench for the antialiased line rasterizer with a pixel scoreboard.
module antialiased_line_raster_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MaxCanvas = 4096;
	localparam int IdleLimit = 4000;
	localparam int DrainCycles = 24;
	localparam int ReportLimit = 10;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [8:0] cov;
		logic [3:0][7:0] chan;
		logic last;
		logic done;
	} pixel_t;

	class line_pixel_scoreboard;
		int canvas_w = MaxCanvas;
		int canvas_h = MaxCanvas;
		int pos_x, pos_y, err_acc, major_len, minor_len, steps_left;
		bit x_neg, y_neg, x_is_major;
		logic [31:0] color = '0;
		pixel_t item_pixels[$];
		pixel_t pending_pixels[$];
		int failures;

		function int clamp_canvas(int r);
			return (r > MaxCanvas) ? MaxCanvas : r;
		endfunction

		function void set_canvas(logic [aalr_pkg::RegIdxW-1:0] idx,
				logic [aalr_pkg::CanvasW-1:0] value);
			if (idx == aalr_pkg::RegCanvasWidth) begin
				canvas_w = value;
			end else begin
				canvas_h = value;
			end
		endfunction

		function void add_pixel(int x, int y, int w);
			pixel_t p;
			int c;
			if (w <= 0 || x < 0 || y < 0) return;
			if (x >= clamp_canvas(canvas_w) || y >= clamp_canvas(canvas_h)) return;
			if (item_pixels.size() >= 2) return;
			p = '0;
			p.x = x[11:0];
			p.y = y[11:0];
			p.cov = w[8:0];
			for (int k = 0; k < 4; k++) begin
				c = color[8*k +: 8];
				p.chan[k] = 8'((c * w) >> 8);
			end
			item_pixels.push_back(p);
		endfunction

		// Works out the pixels caused by one accepted item and queues them.
		function void note_item(logic op, logic signed [15:0] sx, logic signed [15:0] sy,
				logic signed [15:0] ex, logic signed [15:0] ey, logic [31:0] col);
			int dx, dy, ax, ay, m, mn, s, minc, ninc, d, ad, w;
			item_pixels.delete();
			if (op == aalr_pkg::OpStart) begin
				dx = int'(ex) - int'(sx);
				dy = int'(ey) - int'(sy);
				ax = (dx < 0) ? -dx : dx;
				ay = (dy < 0) ? -dy : dy;
				color = col;
				pos_x = sx;
				pos_y = sy;
				err_acc = 0;
				x_neg = !(dx > 0);
				y_neg = !(dy > 0);
				x_is_major = (ax >= ay);
				major_len = x_is_major ? ax : ay;
				minor_len = x_is_major ? ay : ax;
				steps_left = major_len;
				add_pixel(pos_x, pos_y, aalr_pkg::FullWeight);
			end else if (steps_left > 0 && major_len > 0) begin
				m = x_is_major ? pos_x : pos_y;
				mn = x_is_major ? pos_y : pos_x;
				minc = (x_is_major ? x_neg : y_neg) ? -1 : 1;
				ninc = (x_is_major ? y_neg : x_neg) ? -1 : 1;
				m += minc;
				d = err_acc + minor_len;
				if (d <= 0) begin
					s = mn - ninc;
				end else if (d - major_len < 0) begin
					if (2 * d - major_len <= 0) begin
						s = mn + ninc;
					end else begin
						s = mn;
						mn += ninc;
						d -= major_len;
					end
				end else begin
					mn += ninc;
					s = mn + ninc;
					d -= major_len;
				end
				ad = (d < 0) ? -d : d;
				w = (ad * 256) / major_len;
				err_acc = d;
				steps_left--;
				if (x_is_major) begin
					pos_x = m;
					pos_y = mn;
					add_pixel(m, mn, 256 - w);
					add_pixel(m, s, w);
				end else begin
					pos_y = m;
					pos_x = mn;
					add_pixel(mn, m, 256 - w);
					add_pixel(s, m, w);
				end
			end
			foreach (item_pixels[i]) begin
				item_pixels[i].last = (i == item_pixels.size() - 1);
				item_pixels[i].done = (steps_left == 0);
				pending_pixels.push_back(item_pixels[i]);
			end
		endfunction

		function string show(pixel_t p);
			return $sformatf("(%0d,%0d) cov=%0d chan=%h last=%b done=%b",
				p.x, p.y, p.cov, p.chan, p.last, p.done);
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pending_pixels.size() == 0) begin
				failures++;
				if (failures <= ReportLimit) $display("unexpected pixel %s", show(got));
				return;
			end
			want = pending_pixels.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.cov !== want.cov ||
					got.chan !== want.chan || got.last !== want.last ||
					got.done !== want.done) begin
				failures++;
				if (failures <= ReportLimit)
					$display("pixel mismatch: expected %s, got %s", show(want), show(got));
			end
		endfunction

		function void close_out();
			if (pending_pixels.size() != 0) begin
				$display("%0d expected pixels never arrived", pending_pixels.size());
				failures += pending_pixels.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	wire logic in_ready;
	logic opcode;
	logic signed [15:0] start_x, start_y, end_x, end_y;
	logic [31:0] line_color;
	wire logic out_valid;
	logic out_ready;
	wire logic [11:0] pixel_x, pixel_y;
	wire logic [8:0] coverage;
	wire logic [7:0] chan0, chan1, chan2, chan3;
	wire logic last_of_item, line_done;
	logic cfg_valid;
	wire logic cfg_ready;
	logic [0:0] cfg_index;
	logic [12:0] cfg_data;

	antialiased_line_raster dut (.*);

	line_pixel_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int idle_cycles;
	int items_sent;

	int phase_width[6] = '{8191, 40, 1, 0, 4096, 97};
	int phase_height[6] = '{4095, 30, 1, 200, 1, 63};
	int phase_send_pct[4] = '{0, 48, 0, 11};
	int phase_recv_pct[4] = '{0, 0, 48, 11};

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel({pixel_x, pixel_y, coverage, chan3, chan2, chan1, chan0,
				last_of_item, line_done});
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("no handshake for %0d cycles", IdleLimit);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_item(logic op, int sx, int sy, int ex, int ey, logic [31:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		start_x <= 16'(sx);
		start_y <= 16'(sy);
		end_x <= 16'(ex);
		end_y <= 16'(ey);
		line_color <= col;
		do @(posedge clk); while (!in_ready);
		sb.note_item(op, 16'(sx), 16'(sy), 16'(ex), 16'(ey), col);
	endtask

	task automatic send_step();
		items_sent++;
		send_item(aalr_pkg::OpStep, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_canvas_size(int w, int h);
		logic [aalr_pkg::RegIdxW-1:0] idx [2];
		int value [2];
		idx = '{aalr_pkg::RegCanvasWidth, aalr_pkg::RegCanvasHeight};
		value = '{w, h};
		drain();
		cfg_valid <= 1'b1;
		foreach (idx[i]) begin
			cfg_index <= idx[i];
			cfg_data <= 13'(value[i]);
			do @(posedge clk); while (!cfg_ready);
			sb.set_canvas(idx[i], 13'(value[i]));
		end
		cfg_valid <= 1'b0;
	endtask

	// A line near the canvas, usually stepped to its end and a little past it,
	// sometimes cut short by the next start.
	task automatic random_line();
		int span_w, span_h, len, sx, sy, ex, ey, steps;
		span_w = sb.clamp_canvas(sb.canvas_w) + 16;
		span_h = sb.clamp_canvas(sb.canvas_h) + 16;
		len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12);
		sx = int'($urandom_range(span_w)) - 8;
		sy = int'($urandom_range(span_h)) - 8;
		ex = sx + int'($urandom_range(2 * len)) - len;
		ey = sy + int'($urandom_range(2 * len)) - len;
		items_sent++;
		send_item(aalr_pkg::OpStart, sx, sy, ex, ey, $urandom);
		steps = sb.major_len + $urandom_range(2);
		if ($urandom_range(9) == 0) steps = $urandom_range(sb.major_len);
		repeat (steps) send_step();
	endtask

	task automatic noise_burst();
		items_sent++;
		send_item(aalr_pkg::OpStart, $urandom, $urandom, $urandom, $urandom, $urandom);
		repeat ($urandom_range(3)) send_step();
	endtask

	task automatic run_random(int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(99) < 80) begin
				random_line();
			end else begin
				noise_burst();
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = aalr_pkg::OpStart;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		line_color = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = aalr_pkg::RegCanvasWidth;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(aalr_pkg::OpStep, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(aalr_pkg::OpStart, 0, 0, 0, 0, 32'hFFFF_FFFF);
		send_item(aalr_pkg::OpStart, 4095, 4095, 4095, 4095, 32'h0102_0304);
		send_item(aalr_pkg::OpStart, -32768, -32768, 32767, 32767, 32'h8080_8080);
		send_item(aalr_pkg::OpStep, 0, 0, 0, 0, 0);
		send_item(aalr_pkg::OpStart, 32767, 0, -32768, 5, 32'h7F7F_7F7F);
		send_item(aalr_pkg::OpStep, -1, -1, -1, -1, 32'hFFFF_FFFF);
		send_item(aalr_pkg::OpStart, 0, 0, 5, 2, 32'h80FF_0001);
		repeat (6) send_step();
		send_item(aalr_pkg::OpStart, 10, 3, 8, 12, 32'hFFFF_FFFF);
		repeat (3) send_step();
		send_item(aalr_pkg::OpStart, 4096, 10, 4092, 14, 32'h1234_5678);
		repeat (5) send_step();

		for (int p = 0; p < 6; p++) begin
			set_canvas_size(phase_width[p], phase_height[p]);
			send_idle_pct = phase_send_pct[p % 4];
			recv_stall_pct = phase_recv_pct[p % 4];
			if (p == 0) begin
				@(negedge clk);
				hold_request = 300;
				@(posedge clk);
			end
			run_random(137);
		end

		drain();
		sb.close_out();
		if (sb.failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
